// ===== rtl/core/icp_pkg.sv =====
package icp_pkg;

  // Result word: outside flag in bit 0, zero fill up to a byte.
  localparam int unsigned OUT_W = 8;

  // Control that travels with a request from the difference/product half
  // into the lifted-product half.
  typedef struct packed {
    logic valid;
    logic orient_neg;  // A, B, C clockwise: determinant sign is flipped
  } icp_ctl_t;

endpackage

// ===== rtl/core/icp_prep.sv =====
module icp_prep #(
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned N  = COORD_BITS,
  localparam int unsigned DW = N + 1,
  localparam int unsigned PW = 2 * N + 2,
  localparam int unsigned LW = 2 * N + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [8*N-1:0]       coords_i,
  output icp_pkg::icp_ctl_t    out_ctl_o,
  input  logic                 out_ready_i,
  output logic [3*LW-1:0]      lift_o,
  output logic [3*PW-1:0]      cross_o
);

  logic signed [N-1:0]  px [3];
  logic signed [N-1:0]  py [3];
  logic signed [N-1:0]  qx, qy;

  logic                 v1_q, v2_q, v3_q;
  logic                 rdy1, rdy2, rdy3;

  // stage 1: coordinate differences
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [DW-1:0] x_q [3];
  logic signed [DW-1:0] y_q [3];

  // stage 2: products
  logic signed [PW-1:0] pu_q, pv_q;
  logic signed [PW-1:0] sx_q [3];
  logic signed [PW-1:0] sy_q [3];
  logic signed [PW-1:0] mp_q [3];
  logic signed [PW-1:0] mn_q [3];

  // stage 3: lifted terms, 2x2 minors, orientation sign
  logic        [LW-1:0] l_q [3];
  logic signed [PW-1:0] c_q [3];
  logic                 oneg_q;

  assign qx = coords_i[6*N +: N];
  assign qy = coords_i[7*N +: N];

  for (genvar r = 0; r < 3; r++) begin : g_pt
    assign px[r] = coords_i[2*r*N +: N];
    assign py[r] = coords_i[(2*r+1)*N +: N];
    assign lift_o[r*LW +: LW]  = l_q[r];
    assign cross_o[r*PW +: PW] = c_q[r];
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign out_ctl_o.valid      = v3_q;
  assign out_ctl_o.orient_neg = oneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ux_q <= DW'(px[1]) - DW'(px[0]);
      uy_q <= DW'(py[1]) - DW'(py[0]);
      vx_q <= DW'(px[2]) - DW'(px[0]);
      vy_q <= DW'(py[2]) - DW'(py[0]);
      for (int r = 0; r < 3; r++) begin
        x_q[r] <= DW'(px[r]) - DW'(qx);
        y_q[r] <= DW'(py[r]) - DW'(qy);
      end
    end
  end

  // minors: c0 = x1*y2 - x2*y1, c1 = x2*y0 - x0*y2, c2 = x0*y1 - x1*y0
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pu_q <= ux_q * vy_q;
      pv_q <= uy_q * vx_q;
      for (int r = 0; r < 3; r++) begin
        sx_q[r] <= x_q[r] * x_q[r];
        sy_q[r] <= y_q[r] * y_q[r];
      end
      mp_q[0] <= x_q[1] * y_q[2];
      mn_q[0] <= x_q[2] * y_q[1];
      mp_q[1] <= x_q[2] * y_q[0];
      mn_q[1] <= x_q[0] * y_q[2];
      mp_q[2] <= x_q[0] * y_q[1];
      mn_q[2] <= x_q[1] * y_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      oneg_q <= pu_q < pv_q;
      for (int r = 0; r < 3; r++) begin
        l_q[r] <= {1'b0, sx_q[r][2*N-1:0]} + {1'b0, sy_q[r][2*N-1:0]};
        c_q[r] <= mp_q[r] - mn_q[r];
      end
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_ready_i |=> v3_q && $stable(lift_o) && $stable(cross_o)
      && $stable(oneg_q))
    else $error("prep output changed while stalled");

  // all lifted terms zero means every point sits on D, so every minor is zero
  a_zero_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && lift_o == '0 |-> cross_o == '0)
    else $error("nonzero minor with degenerate rows");

endmodule

// ===== rtl/core/icp_lift.sv =====
module icp_lift #(
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned N   = COORD_BITS,
  localparam int unsigned PW  = 2 * N + 2,
  localparam int unsigned LW  = 2 * N + 1,
  localparam int unsigned EW  = N + 2,
  localparam int unsigned PPW = 2 * EW,
  localparam int unsigned TW  = 4 * N + 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icp_pkg::icp_ctl_t    in_ctl_i,
  output logic                 in_ready_o,
  input  logic [3*LW-1:0]      lift_i,
  input  logic [3*PW-1:0]      cross_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 outside_o
);

  logic                  v4_q, v5_q, v6_q;
  logic                  rdy4, rdy5, rdy6;
  logic                  oneg4_q, oneg5_q;

  logic signed [EW-1:0]  a_lo [3];
  logic signed [EW-1:0]  a_hi [3];
  logic signed [EW-1:0]  b_lo [3];
  logic signed [EW-1:0]  b_hi [3];

  // partial products of l*c, split at bit N+1 on both operands
  logic signed [PPW-1:0] ll_q [3];
  logic signed [PPW-1:0] lh_q [3];
  logic signed [PPW-1:0] hl_q [3];
  logic signed [PPW-1:0] hh_q [3];

  logic signed [TW-1:0]  t_q [3];
  logic signed [TW-1:0]  det;
  logic                  outside_q;

  for (genvar r = 0; r < 3; r++) begin : g_split
    assign a_lo[r] = $signed({1'b0, lift_i[r*LW +: N+1]});
    assign a_hi[r] = $signed({2'b00, lift_i[r*LW+N+1 +: N]});
    assign b_lo[r] = $signed({1'b0, cross_i[r*PW +: N+1]});
    assign b_hi[r] = $signed({cross_i[r*PW+PW-1], cross_i[r*PW+N+1 +: N+1]});
  end

  assign rdy6        = !v6_q || out_ready_i;
  assign rdy5        = !v5_q || rdy6;
  assign rdy4        = !v4_q || rdy5;
  assign in_ready_o  = rdy4;
  assign out_valid_o = v6_q;
  assign outside_o   = outside_q;

  assign det = t_q[0] + t_q[1] + t_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_ctl_i.valid;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_ctl_i.valid) begin
      oneg4_q <= in_ctl_i.orient_neg;
      for (int r = 0; r < 3; r++) begin
        ll_q[r] <= a_lo[r] * b_lo[r];
        lh_q[r] <= a_lo[r] * b_hi[r];
        hl_q[r] <= a_hi[r] * b_lo[r];
        hh_q[r] <= a_hi[r] * b_hi[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      oneg5_q <= oneg4_q;
      for (int r = 0; r < 3; r++) begin
        t_q[r] <= TW'(ll_q[r]) + (TW'(lh_q[r]) <<< (N + 1))
                + (TW'(hl_q[r]) <<< (N + 1)) + (TW'(hh_q[r]) <<< (2 * N + 2));
      end
    end
  end

  // clockwise triangle: swapping B and C negates the determinant
  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      outside_q <= oneg5_q ? (!det[TW-1] && det != '0) : det[TW-1];
    end
  end

endmodule

// ===== rtl/core/incircle_predicate.sv =====
// Delaunay in-circle test on integer grid points.
// Request channel (s_axis): one request per beat carries points A, B, C and
// the query point D as signed COORD_BITS-bit coordinates. Result channel
// (m_axis): one beat per request, in request order; bit 0 is 1 when D lies
// strictly outside the circumcircle of A, B, C (clockwise triangles are
// handled by flipping the determinant sign), 0 when inside or on the circle.
// Six register stages: differences, 2x2 products, lifted terms and minors,
// split partial products, term sums, sign of the determinant. Throughput is
// one request per cycle while m_axis_tready_i is high; the widest multiply
// is (COORD_BITS+2) x (COORD_BITS+2) bits, twelve of them in stage four.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up. When m_axis_tready_i is low the
// result stays in the output register and up to six requests fill the
// pipeline before s_axis_tready_o drops.
// Reset empties all stages; nothing is held across reset.
module incircle_predicate #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // ax, ay, bx, by, cx, cy, qx, qy from bit 0 up, COORD_BITS each
  input  logic [8*COORD_BITS-1:0]     s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // outside in bit 0, zeros above
  output logic [icp_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned LW = 2 * COORD_BITS + 1;

  icp_pkg::icp_ctl_t   mid_ctl;
  logic                mid_ready;
  logic [3*LW-1:0]     mid_lift;
  logic [3*PW-1:0]     mid_cross;
  logic                outside;

  icp_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .coords_i    (s_axis_tdata_i),
    .out_ctl_o   (mid_ctl),
    .out_ready_i (mid_ready),
    .lift_o      (mid_lift),
    .cross_o     (mid_cross)
  );

  icp_lift #(
    .COORD_BITS (COORD_BITS)
  ) u_lift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctl_i    (mid_ctl),
    .in_ready_o  (mid_ready),
    .lift_i      (mid_lift),
    .cross_i     (mid_cross),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .outside_o   (outside)
  );

  assign m_axis_tdata_o = {{(icp_pkg::OUT_W-1){1'b0}}, outside};

  // an empty output stage lets the whole ready chain open
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request stalled with empty output stage");

  a_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("request stalled while result side is ready");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o || $past(rst_ni))
    else $error("result valid right after reset");

endmodule

// ===== test/incircle_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the in-circle unit, predicts the outside flag for
// every accepted request and compares it with the result stream in order.
module incircle_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [8*COORD_BITS-1:0]     s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [icp_pkg::OUT_W-1:0]   m_tdata_i,
  output int                          err_cnt_o,
  output int                          pending_o
);

  logic outside_q[$];

  function automatic longint coord(input logic [8*COORD_BITS-1:0] req, input int idx);
    logic signed [COORD_BITS-1:0] c;
    c = req[idx*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  // Exact lifted determinant; 128 bits is far more than the ~70 needed.
  function automatic logic outside_of(input logic [8*COORD_BITS-1:0] req);
    longint            xs[3];
    longint            ys[3];
    longint            qx, qy, orient, t;
    logic signed [127:0] mx[3];
    logic signed [127:0] my[3];
    logic signed [127:0] mw[3];
    logic signed [127:0] det;
    int                r;
    for (r = 0; r < 3; r++) begin
      xs[r] = coord(req, 2*r);
      ys[r] = coord(req, 2*r+1);
    end
    qx = coord(req, 6);
    qy = coord(req, 7);
    orient = (xs[1]-xs[0])*(ys[2]-ys[0]) - (ys[1]-ys[0])*(xs[2]-xs[0]);
    // clockwise: swap B and C; collinear stays as is
    if (orient < 0) begin
      t = xs[1]; xs[1] = xs[2]; xs[2] = t;
      t = ys[1]; ys[1] = ys[2]; ys[2] = t;
    end
    for (r = 0; r < 3; r++) begin
      mx[r] = xs[r] - qx;
      my[r] = ys[r] - qy;
      mw[r] = mx[r]*mx[r] + my[r]*my[r];
    end
    det = mx[0]*my[1]*mw[2] + my[0]*mw[1]*mx[2] + mw[0]*mx[1]*my[2]
        - mw[0]*my[1]*mx[2] - mx[0]*mw[1]*my[2] - my[0]*mx[1]*mw[2];
    return det < 0;
  endfunction

  // err_cnt_o and pending_o are two-state and start at zero
  always @(posedge clk_i) begin : watch
    logic exp_outside;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) outside_q.push_back(outside_of(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (outside_q.size() == 0) begin
          err_cnt_o = err_cnt_o + 1;
          $error("outside: expected none, got %0d", m_tdata_i[0]);
        end else begin
          exp_outside = outside_q.pop_front();
          if (m_tdata_i[0] !== exp_outside) begin
            err_cnt_o = err_cnt_o + 1;
            $error("outside: expected %0d, got %0d", exp_outside, m_tdata_i[0]);
          end
          if (m_tdata_i[icp_pkg::OUT_W-1:1] !== '0) begin
            err_cnt_o = err_cnt_o + 1;
            $error("pad: expected 0, got %0h", m_tdata_i[icp_pkg::OUT_W-1:1]);
          end
        end
      end
    end
    pending_o = outside_q.size();
  end

endmodule

// ===== test/tb_incircle_predicate.sv =====
`timescale 1ns / 1ps

module tb_incircle_predicate;

  localparam int unsigned COORD_BITS = 16;
  localparam int          N_RANDOM   = 1600;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        s_valid = 1'b0;
  logic                        s_ready;
  logic [8*COORD_BITS-1:0]     s_data = '0;
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [icp_pkg::OUT_W-1:0]   m_data;
  int                          errors;
  int                          pending;

  bit no_idle  = 1'b0;
  int hold_cnt = 0;

  // lattice points on a circle of radius 5
  int lat_x[12] = '{5, 4, 3, 0, -3, -4, -5, -4, -3, 0, 3, 4};
  int lat_y[12] = '{0, 3, 4, 5, 4, 3, 0, -3, -4, -5, -4, -3};

  incircle_predicate #(.COORD_BITS(COORD_BITS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  incircle_checker #(.COORD_BITS(COORD_BITS)) chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_valid),
    .s_tready_i(s_ready),
    .s_tdata_i (s_data),
    .m_tvalid_i(m_valid),
    .m_tready_i(m_ready),
    .m_tdata_i (m_data),
    .err_cnt_o (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, mostly short, now and then long ready runs
  always @(posedge clk_i) begin : sink
    int r;
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        m_ready <= 1'b1;
        hold_cnt = $urandom_range(0, 8);
      end else if (r < 55) begin
        m_ready <= 1'b1;
        hold_cnt = $urandom_range(50, 150);
      end else if (r < 85) begin
        m_ready <= 1'b0;
        hold_cnt = $urandom_range(0, 3);
      end else if (r < 97) begin
        m_ready <= 1'b0;
        hold_cnt = $urandom_range(4, 12);
      end else begin
        m_ready <= 1'b0;
        hold_cnt = $urandom_range(20, 40);
      end
    end
  end

  function automatic logic [8*COORD_BITS-1:0] pack_pts(input int ax, ay, bx, by,
                                                       cx, cy, qx, qy);
    return {qy[COORD_BITS-1:0], qx[COORD_BITS-1:0], cy[COORD_BITS-1:0],
            cx[COORD_BITS-1:0], by[COORD_BITS-1:0], bx[COORD_BITS-1:0],
            ay[COORD_BITS-1:0], ax[COORD_BITS-1:0]};
  endfunction

  // returns at the edge where the request is taken
  task automatic send_req(input logic [8*COORD_BITS-1:0] req);
    int r;
    int gap;
    gap = 0;
    if (!no_idle) begin
      r = $urandom_range(0, 99);
      if (r < 60)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= req;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send_pts(input int ax, ay, bx, by, cx, cy, qx, qy);
    send_req(pack_pts(ax, ay, bx, by, cx, cy, qx, qy));
  endtask

  initial begin : stim
    int i, j, mode, idx, ccx, ccy, k, t, s, dx, dy;
    int p[8];
    int extremes[8];
    extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767, -21846};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pts(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    // corners of the full square lie on one circle
    send_pts(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    send_pts(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
    send_pts(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
    send_pts(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0);
    send_pts(1, 0, 0, 1, -1, 0, 0, -1);
    send_pts(1, 0, 0, 1, -1, 0, 0, -2);
    send_pts(1, 0, -1, 0, 0, 1, 0, -2);
    send_pts(1, 0, -1, 0, 0, 1, 0, 0);
    // collinear and nearly collinear triangles
    send_pts(0, 0, 1, 1, 2, 2, 5, -3);
    send_pts(0, 0, 1, 1, 2, 2, 7, 7);
    send_pts(-32768, 32767, 0, 0, 32767, -32767, -32768, -32768);
    // a repeated vertex, then triangles at or near the corners of the square
    send_pts(5, 5, 5, 5, -7, 3, 100, 100);
    send_pts(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768);
    send_pts(32767, 32767, 32766, 32767, 32767, 32766, -32768, -32768);
    send_pts(32767, 32767, 32767, 32766, 32766, 32767, 32767, 32766);
    // query on a vertex
    send_pts(3, 4, -4, 3, 0, -5, 3, 4);
    send_pts(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846);
    send_pts(-1, 1, 1, -1, -1, -1, 1, 1);
    send_pts(-1, 1, 1, -1, -1, -1, 0, 0);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 25) begin
        send_req({$urandom, $urandom, $urandom, $urandom});
      end else if (mode < 55) begin
        // points on a scaled lattice circle, query on it or one step off
        ccx = int'($urandom_range(0, 40000)) - 20000;
        ccy = int'($urandom_range(0, 40000)) - 20000;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 4);
        for (j = 0; j < 4; j++) begin
          idx = $urandom_range(0, 11);
          p[2*j]   = ccx + k*lat_x[idx];
          p[2*j+1] = ccy + k*lat_y[idx];
        end
        if ($urandom_range(0, 1) == 1) begin
          p[6] = p[6] + int'($urandom_range(0, 2)) - 1;
          p[7] = p[7] + int'($urandom_range(0, 2)) - 1;
        end
        send_pts(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
      end else if (mode < 70) begin
        p[0] = int'($urandom_range(0, 20000)) - 10000;
        p[1] = int'($urandom_range(0, 20000)) - 10000;
        dx = int'($urandom_range(0, 10)) - 5;
        dy = int'($urandom_range(0, 10)) - 5;
        t = int'($urandom_range(0, 2000)) - 1000;
        s = int'($urandom_range(0, 2000)) - 1000;
        send_pts(p[0], p[1], p[0] + t*dx, p[1] + t*dy, p[0] + s*dx, p[1] + s*dy,
                 int'($urandom_range(0, 60000)) - 30000,
                 int'($urandom_range(0, 60000)) - 30000);
      end else if (mode < 85) begin
        for (j = 0; j < 8; j++) p[j] = int'($urandom_range(0, 8)) - 4;
        send_pts(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
      end else begin
        for (j = 0; j < 8; j++) p[j] = extremes[$urandom_range(0, 7)];
        send_pts(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
      end
    end
    s_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
